// ===== design/ifs_pkg.sv =====
// ifs_pkg: shared types and constants of the ipd frame stripper
// holds marker bytes, parse mode codes and the controller/datapath interface structs
// no dependencies
package ifs_pkg;

	localparam int unsigned HOLD_DEPTH = 10;
	localparam int unsigned CNT_W      = $clog2(HOLD_DEPTH + 1);
	localparam int unsigned IDX_W      = $clog2(HOLD_DEPTH);
	localparam int unsigned HDR_LEN    = 9;
	localparam int unsigned TRM_LEN    = 10;

	typedef logic [7:0] byte_t;

	localparam byte_t HDR_MARK [HDR_LEN] = '{
		8'h0D, 8'h0A, 8'h0D, 8'h0A, 8'h2B, 8'h49, 8'h50, 8'h44, 8'h2C
	};
	localparam byte_t TRM_MARK [TRM_LEN] = '{
		8'h0D, 8'h0A, 8'h43, 8'h4C, 8'h4F, 8'h53, 8'h45, 8'h44, 8'h0D, 8'h0A
	};
	localparam byte_t COLON = 8'h3A;

	localparam logic [1:0] MODE_COPY   = 2'd0;
	localparam logic [1:0] MODE_SKIP   = 2'd1;
	localparam logic [1:0] MODE_CLOSED = 2'd2;

	typedef struct packed {
		logic load;
		logic append;
		logic release_old;
		logic hdr_hit;
		logic trm_hit;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       fend;
		logic       full;
		logic       empty;
		logic       hdr_done;
		logic       trm_done;
		logic       prefix_ok;
		logic       emit_ok;
		logic       flush_ok;
	} sts_t;

endpackage

// ===== design/ifs_ctrl.sv =====
// ifs_ctrl: sequencing state machine of the ipd frame stripper
// issues ifs_pkg::cmd_t commands from ifs_pkg::sts_t status of ifs_datapath
// depends on ifs_pkg
module ifs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  ifs_pkg::sts_t sts,
	output ifs_pkg::cmd_t cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_APPEND = 2'd1;
	localparam logic [1:0] ST_SCAN   = 2'd2;
	localparam logic [1:0] ST_FEND   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = (sts.mode == ifs_pkg::MODE_COPY) ? ST_APPEND : ST_FEND;
				end
			end
			ST_APPEND: begin
				if (!sts.full) begin
					cmd.append = 1'b1;
					state_d    = ST_SCAN;
				end else if (sts.emit_ok) begin
					cmd.release_old = 1'b1;
				end
			end
			ST_SCAN: begin
				if (sts.hdr_done) begin
					cmd.hdr_hit = 1'b1;
					state_d     = ST_FEND;
				end else if (sts.trm_done) begin
					if (sts.emit_ok) begin
						cmd.trm_hit = 1'b1;
						state_d     = ST_FEND;
					end
				end else if (sts.prefix_ok) begin
					state_d = ST_FEND;
				end else if (sts.emit_ok) begin
					cmd.release_old = 1'b1;
				end
			end
			ST_FEND: begin
				if (sts.fend && !sts.empty) begin
					if (sts.emit_ok) begin
						cmd.release_old = 1'b1;
					end
				end else if (sts.flush_ok) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== design/ifs_datapath.sv =====
// ifs_datapath: hold window, marker compare, parse mode and result registers
// executes ifs_pkg::cmd_t commands, reports ifs_pkg::sts_t status
// depends on ifs_pkg
module ifs_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    in_byte,
	input  logic          frame_end,
	input  ifs_pkg::cmd_t cmd,
	output ifs_pkg::sts_t sts,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    out_byte,
	output logic          data_valid,
	output logic          run_last,
	output logic          closed_seen
);

	ifs_pkg::byte_t             win_q [ifs_pkg::HOLD_DEPTH];
	logic [ifs_pkg::CNT_W-1:0]  count_q;
	logic [1:0]                 mode_q;
	ifs_pkg::byte_t             byte_q;
	logic                       fend_q;

	logic                       pend_v_q;
	ifs_pkg::byte_t             pend_byte_q;
	logic                       pend_dv_q;
	logic                       pend_cl_q;

	logic                       out_v_q;
	ifs_pkg::byte_t             out_byte_q;
	logic                       out_dv_q;
	logic                       out_last_q;
	logic                       out_cl_q;

	logic                       out_free;
	logic                       emit;
	ifs_pkg::byte_t             emit_byte;
	logic                       emit_dv;
	logic                       emit_cl;
	logic                       hdr_pre;
	logic                       trm_pre;

	always_comb begin
		hdr_pre = (count_q <= ifs_pkg::CNT_W'(ifs_pkg::HDR_LEN));
		trm_pre = (count_q <= ifs_pkg::CNT_W'(ifs_pkg::TRM_LEN));
		for (int i = 0; i < ifs_pkg::HDR_LEN; i++) begin
			if ((ifs_pkg::CNT_W'(i) < count_q) && (win_q[i] != ifs_pkg::HDR_MARK[i])) begin
				hdr_pre = 1'b0;
			end
		end
		for (int i = 0; i < ifs_pkg::TRM_LEN; i++) begin
			if ((ifs_pkg::CNT_W'(i) < count_q) && (win_q[i] != ifs_pkg::TRM_MARK[i])) begin
				trm_pre = 1'b0;
			end
		end
	end

	assign out_free = !out_v_q || !out_stall;

	always_comb begin
		sts           = '0;
		sts.mode      = mode_q;
		sts.fend      = fend_q;
		sts.full      = (count_q >= ifs_pkg::CNT_W'(ifs_pkg::HOLD_DEPTH));
		sts.empty     = (count_q == '0);
		sts.hdr_done  = (count_q == ifs_pkg::CNT_W'(ifs_pkg::HDR_LEN)) && hdr_pre;
		sts.trm_done  = (count_q == ifs_pkg::CNT_W'(ifs_pkg::TRM_LEN)) && trm_pre;
		sts.prefix_ok = (count_q == '0) || hdr_pre || trm_pre;
		sts.emit_ok   = !pend_v_q || out_free;
		sts.flush_ok  = !pend_v_q || out_free;
	end

	assign emit      = cmd.release_old || cmd.trm_hit;
	assign emit_byte = cmd.trm_hit ? 8'h00 : win_q[0];
	assign emit_dv   = !cmd.trm_hit;
	assign emit_cl   = cmd.trm_hit;

	// window, input byte and result data storage, no reset
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= in_byte;
		end
		if (cmd.append) begin
			win_q[count_q[ifs_pkg::IDX_W-1:0]] <= byte_q;
		end else if (cmd.release_old) begin
			for (int i = 0; i < ifs_pkg::HOLD_DEPTH - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
		end
		if (emit) begin
			pend_byte_q <= emit_byte;
			pend_dv_q   <= emit_dv;
			pend_cl_q   <= emit_cl;
		end
		if ((emit || cmd.finish) && pend_v_q) begin
			out_byte_q <= pend_byte_q;
			out_dv_q   <= pend_dv_q;
			out_cl_q   <= pend_cl_q;
			out_last_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			mode_q   <= ifs_pkg::MODE_COPY;
			fend_q   <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				fend_q <= frame_end;
				if ((mode_q == ifs_pkg::MODE_SKIP) && (in_byte == ifs_pkg::COLON)) begin
					mode_q <= ifs_pkg::MODE_COPY;
				end
			end
			if (cmd.append) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.release_old) begin
				count_q <= count_q - 1'b1;
			end else if (cmd.hdr_hit) begin
				count_q <= '0;
				mode_q  <= ifs_pkg::MODE_SKIP;
			end else if (cmd.trm_hit) begin
				count_q <= '0;
				mode_q  <= ifs_pkg::MODE_CLOSED;
			end else if (cmd.finish && fend_q) begin
				count_q <= '0;
				mode_q  <= ifs_pkg::MODE_COPY;
			end
			if (emit) begin
				pend_v_q <= 1'b1;
			end else if (cmd.finish) begin
				pend_v_q <= 1'b0;
			end
			if ((emit || cmd.finish) && pend_v_q) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_v_q;
	assign out_byte    = out_byte_q;
	assign data_valid  = out_dv_q;
	assign run_last    = out_last_q;
	assign closed_seen = out_cl_q;

endmodule

// ===== design/ipd_frame_stripper_core.sv =====
// ipd_frame_stripper_core: top level of the ipd frame stripper
// instantiates ifs_ctrl and ifs_datapath, depends on ifs_pkg
//
// Strips the CR LF CR LF "+IPD," header and its length digits through ':' from a modem
// byte stream, passes payload bytes, and reports the CR LF "CLOSED" CR LF terminator as one
// result with closed_seen set; bytes after it are dropped until a frame_end byte resets the
// block. Bytes that may still begin a marker are held in a ten-byte window and released in
// order once the window stops matching. A byte in copy mode passes the controller's append,
// scan and frame-end steps, with one release step for each held byte released; a byte
// outside copy mode goes straight to the frame-end step. No new byte is taken until idle.
// Each result for a byte is delayed by one slot so run_last can be set on the final one.
module ipd_frame_stripper_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       frame_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       data_valid,
	output logic       run_last,
	output logic       closed_seen
);

	ifs_pkg::cmd_t cmd;
	ifs_pkg::sts_t sts;

	ifs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ifs_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_byte     (in_byte),
		.frame_end   (frame_end),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.data_valid  (data_valid),
		.run_last    (run_last),
		.closed_seen (closed_seen)
	);

endmodule

// ===== verif/tb_ipd_frame_stripper_core.sv =====
// tb_ipd_frame_stripper_core: self-checking testbench for the ipd frame stripper core
// drives framed and noisy modem byte streams, predicts the stripped payload and compares
// depends on ifs_pkg and ipd_frame_stripper_core
module tb_ipd_frame_stripper_core;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		ifs_pkg::byte_t data;
		logic           fend;
	} rx_byte_t;

	typedef struct {
		ifs_pkg::byte_t data;
		logic           payload;
		logic           last;
		logic           closed;
	} strip_res_t;

	localparam int unsigned CYCLE_LIMIT  = 100000;
	localparam int unsigned TARGET_ITEMS = 410;
	localparam int unsigned MAX_PER_BYTE = 10;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte   = 8'h00;
	logic       frame_end = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       data_valid;
	logic       run_last;
	logic       closed_seen;

	rx_byte_t       stim_q[$];
	strip_res_t     payload_q[$];
	ifs_pkg::byte_t held_q[$];
	logic [1:0]     parse_mode = ifs_pkg::MODE_COPY;
	logic           in_taken   = 1'b0;
	int unsigned n_accepted = 0;
	int unsigned n_results  = 0;
	int unsigned n_closed   = 0;
	int unsigned n_frames   = 0;
	int unsigned n_noise    = 0;
	int unsigned err_count  = 0;
	int unsigned cycle_count = 0;

	ipd_frame_stripper_core u_top (.*);

	always #5 clk = ~clk;

	task automatic report_mismatch(string msg);
		$display("%0t ns: mismatch: %s", $realtime, msg);
		err_count++;
	endtask

	function automatic bit window_on_mark(bit trm);
		int unsigned n = held_q.size();
		if (n > (trm ? ifs_pkg::TRM_LEN : ifs_pkg::HDR_LEN) || n > ifs_pkg::HOLD_DEPTH)
			return 1'b0;
		for (int unsigned i = 0; i < n; i++) begin
			if (trm) begin
				if (held_q[i] != ifs_pkg::TRM_MARK[i])
					return 1'b0;
			end else if (held_q[i] != ifs_pkg::HDR_MARK[i]) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	task automatic push_res(ref strip_res_t step_q[$], input ifs_pkg::byte_t d,
			input logic v, input logic c);
		if (step_q.size() < MAX_PER_BYTE)
			step_q.push_back('{d, v, 1'b0, c});
	endtask

	task automatic release_held(ref strip_res_t step_q[$]);
		if (held_q.size() > 0)
			push_res(step_q, held_q.pop_front(), 1'b1, 1'b0);
	endtask

	task automatic strip_byte(input ifs_pkg::byte_t b, input logic fend);
		strip_res_t step_q[$];
		if (parse_mode == ifs_pkg::MODE_COPY) begin
			if (held_q.size() >= ifs_pkg::HOLD_DEPTH)
				release_held(step_q);
			held_q.push_back(b);
			forever begin
				if (held_q.size() == ifs_pkg::HDR_LEN && window_on_mark(1'b0)) begin
					held_q.delete();
					parse_mode = ifs_pkg::MODE_SKIP;
					break;
				end
				if (held_q.size() == ifs_pkg::TRM_LEN && window_on_mark(1'b1)) begin
					held_q.delete();
					parse_mode = ifs_pkg::MODE_CLOSED;
					push_res(step_q, 8'h00, 1'b0, 1'b1);
					n_closed++;
					break;
				end
				if (held_q.size() == 0 || window_on_mark(1'b0) || window_on_mark(1'b1))
					break;
				release_held(step_q);
			end
		end else if (parse_mode == ifs_pkg::MODE_SKIP) begin
			if (b == ifs_pkg::COLON)
				parse_mode = ifs_pkg::MODE_COPY;
		end
		if (fend) begin
			while (held_q.size() > 0)
				release_held(step_q);
			parse_mode = ifs_pkg::MODE_COPY;
		end
		if (step_q.size() > 0)
			step_q[step_q.size() - 1].last = 1'b1;
		foreach (step_q[i])
			payload_q.push_back(step_q[i]);
	endtask

	function automatic bit idle_now();
		return (n_accepted < 150 || n_accepted > 260) && $urandom_range(99) < 11;
	endfunction

	function automatic ifs_pkg::byte_t marker_char();
		if ($urandom_range(1))
			return ifs_pkg::HDR_MARK[$urandom_range(ifs_pkg::HDR_LEN - 1)];
		return ifs_pkg::TRM_MARK[$urandom_range(ifs_pkg::TRM_LEN - 1)];
	endfunction

	function automatic ifs_pkg::byte_t stream_byte();
		if ($urandom_range(9) < 4)
			return marker_char();
		return ifs_pkg::byte_t'($urandom_range(255));
	endfunction

	task automatic put(input ifs_pkg::byte_t b, input logic fe = 1'b0);
		stim_q.push_back('{b, fe});
	endtask

	task automatic put_mark(input bit trm, input int unsigned len);
		for (int unsigned i = 0; i < len; i++) begin
			if (trm)
				put(ifs_pkg::TRM_MARK[i]);
			else
				put(ifs_pkg::HDR_MARK[i]);
		end
	endtask

	task automatic add_frame();
		int unsigned first = stim_q.size();
		int unsigned cut;
		repeat ($urandom_range(3))
			put(stream_byte());
		put_mark(1'b0, ifs_pkg::HDR_LEN);
		repeat ($urandom_range(1, 4))
			put(ifs_pkg::byte_t'(8'h30 + $urandom_range(9)));
		put(ifs_pkg::COLON);
		repeat ($urandom_range(12)) begin
			if ($urandom_range(7) == 0)
				put_mark(1'($urandom_range(1)), $urandom_range(1, 8));
			else
				put(stream_byte());
		end
		if ($urandom_range(4) != 0) begin
			// header prefix right before the terminator
			if ($urandom_range(3) == 0)
				put_mark(1'b0, 4);
			put_mark(1'b1, ifs_pkg::TRM_LEN);
			repeat ($urandom_range(2))
				put(stream_byte());
		end
		cut = ($urandom_range(9) == 0) ? $urandom_range(first, stim_q.size() - 1)
			: stim_q.size() - 1;
		while (stim_q.size() > cut + 1)
			void'(stim_q.pop_back());
		stim_q[cut].fend = 1'b1;
	endtask

	task automatic add_noise();
		repeat ($urandom_range(1, 15))
			put(stream_byte(), $urandom_range(5) == 0);
		stim_q[stim_q.size() - 1].fend = 1'b1;
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			out_stall <= 1'b0;
		end else begin
			out_stall <= idle_now();
			if (!in_valid || in_taken) begin
				if (stim_q.size() > 0 && !idle_now()) begin
					in_valid  <= 1'b1;
					in_byte   <= stim_q[0].data;
					frame_end <= stim_q[0].fend;
					void'(stim_q.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		strip_res_t want;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				strip_byte(in_byte, frame_end);
				n_accepted++;
			end
			if (out_valid && !out_stall) begin
				n_results++;
				if (payload_q.size() == 0) begin
					report_mismatch($sformatf("result %0d (byte %02h) with nothing pending",
						n_results, out_byte));
				end else begin
					want = payload_q.pop_front();
					if (out_byte !== want.data)
						report_mismatch($sformatf("result %0d: out_byte %02h, expected %02h",
							n_results, out_byte, want.data));
					if (data_valid !== want.payload)
						report_mismatch($sformatf("result %0d: data_valid %b, expected %b",
							n_results, data_valid, want.payload));
					if (run_last !== want.last)
						report_mismatch($sformatf("result %0d: run_last %b, expected %b",
							n_results, run_last, want.last));
					if (closed_seen !== want.closed)
						report_mismatch($sformatf("result %0d: closed_seen %b, expected %b",
							n_results, closed_seen, want.closed));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending", cycle_count,
				payload_q.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		int unsigned total;
		// extremes, header with length, payload, terminator, closed mode, flush of held bytes
		put(8'h00);
		put_mark(1'b0, ifs_pkg::HDR_LEN);
		put(8'h37);
		put(ifs_pkg::COLON);
		put(8'hFF);
		put(8'h0D);
		put(8'h0A);
		put_mark(1'b1, ifs_pkg::TRM_LEN);
		put(8'h55, 1'b1);
		put(8'h0D);
		put(8'h0A);
		put(8'h0D, 1'b1);
		while (stim_q.size() < TARGET_ITEMS) begin
			if ($urandom_range(99) < 80) begin
				add_frame();
				n_frames++;
			end else begin
				add_noise();
				n_noise++;
			end
		end
		total = stim_q.size();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (n_accepted == total);
		while (payload_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (payload_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", payload_q.size()));

		$display("sent %0d stream bytes: %0d framed messages and %0d noise bursts",
			total, n_frames, n_noise);
		$display("checked %0d results including %0d terminators, %0d mismatches",
			n_results, n_closed, err_count);
		if (err_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== sim.f =====
design/ifs_pkg.sv
design/ifs_ctrl.sv
design/ifs_datapath.sv
design/ipd_frame_stripper_core.sv
verif/tb_ipd_frame_stripper_core.sv
